FILE: rtl/bed_pkg.sv
// Shared constants and types for the button event detector.
`timescale 1ns / 1ps
`default_nettype none

package bed_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int MASK_W      = 16;
    localparam int TIME_W      = 32;
    localparam int IDX_W       = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [1:0] CMD_SCAN  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_ENABLE = 1'b1;

    localparam logic [TIME_W-1:0] LONG_PRESS_MS_RST     = 32'd1000;
    localparam logic [MASK_W-1:0] LONG_PRESS_ENABLE_RST = 16'hFFFF;

    // Per-lane view of the current transaction
    typedef struct packed {
        logic accept;
        logic scan;
        logic read_hit;
        logic clear_all;
    } lane_ctrl_t;

    // What one lane found for the current transaction
    typedef struct packed {
        logic       held_next;
        logic       press_hit;
        logic       release_hit;
        logic       long_hit;
        logic [1:0] rd_event;
        logic       rd_pressed;
    } lane_stat_t;

    typedef struct packed {
        logic [1:0]        event_code;
        logic              button_pressed;
        logic [MASK_W-1:0] pressed_mask;
        logic [MASK_W-1:0] press_events_mask;
        logic [MASK_W-1:0] release_events_mask;
        logic [MASK_W-1:0] long_events_mask;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/bed_lane.sv
// One button lane: level tracking, hold timer compare and pending event.
`timescale 1ns / 1ps
`default_nettype none

module bed_lane (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bed_pkg::lane_ctrl_t        ctrl,
    input  wire logic                       level,
    input  wire logic                       long_en,
    input  wire logic [bed_pkg::TIME_W-1:0] now_ms,
    input  wire logic [bed_pkg::TIME_W-1:0] long_press_ms,
    output bed_pkg::lane_stat_t             stat
);

    logic                       held_reg;
    logic                       held_next;
    logic                       fired_reg;
    logic                       fired_next;
    logic [1:0]                 pend_reg;
    logic [1:0]                 pend_next;
    logic [bed_pkg::TIME_W-1:0] start_reg;
    logic                       start_load;
    logic [bed_pkg::TIME_W-1:0] elapsed;
    logic                       rise;
    logic                       fall;
    logic                       long_cond;

    assign rise      = level & ~held_reg;
    assign fall      = ~level & held_reg;
    // held time wraps modulo 2^32
    assign elapsed   = now_ms - start_reg;
    assign long_cond = level & held_reg & long_en & ~fired_reg & (elapsed >= long_press_ms);

    always_comb
    begin
        held_next  = held_reg;
        fired_next = fired_reg;
        pend_next  = pend_reg;
        start_load = 1'b0;
        if (ctrl.accept)
        begin
            if (ctrl.scan)
            begin
                priority if (rise)
                begin
                    held_next  = 1'b1;
                    fired_next = 1'b0;
                    pend_next  = bed_pkg::EV_PRESS;
                    start_load = 1'b1;
                end
                else if (fall)
                begin
                    held_next = 1'b0;
                    pend_next = bed_pkg::EV_RELEASE;
                end
                else if (long_cond)
                begin
                    fired_next = 1'b1;
                    pend_next  = bed_pkg::EV_LONG;
                end
            end
            if (ctrl.read_hit || ctrl.clear_all)
            begin
                pend_next = bed_pkg::EV_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            fired_reg <= 1'b0;
            pend_reg  <= bed_pkg::EV_NONE;
        end
        else
        begin
            held_reg  <= held_next;
            fired_reg <= fired_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_load)
        begin
            start_reg <= now_ms;
        end
    end

    always_comb
    begin
        stat.held_next   = ctrl.scan ? level : held_reg;
        stat.press_hit   = ctrl.scan & rise;
        stat.release_hit = ctrl.scan & fall;
        stat.long_hit    = ctrl.scan & ~rise & ~fall & long_cond;
        stat.rd_event    = ctrl.read_hit ? pend_reg : bed_pkg::EV_NONE;
        stat.rd_pressed  = ctrl.read_hit & held_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/bed_merge.sv
// Merge of lane results into masks and read data, with a two-entry output buffer.
`timescale 1ns / 1ps
`default_nettype none

module bed_merge (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire bed_pkg::lane_stat_t [bed_pkg::NUM_BUTTONS-1:0]    lane_stat,
    input  wire logic                                              take,
    input  wire logic                                              out_stall,
    output logic                                                   full,
    output logic                                                   out_valid,
    output bed_pkg::result_t                                       result
);

    bed_pkg::result_t merged;
    bed_pkg::result_t out_data_reg;
    bed_pkg::result_t out_data_next;
    bed_pkg::result_t skid_data_reg;
    bed_pkg::result_t skid_data_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic             pop;
    logic [1:0]       rd_code;
    logic             rd_pressed;

    // only the first MASK_W buttons show up in the masks
    for (genvar j = 0; j < bed_pkg::MASK_W; j++)
    begin : g_mask
        if (j < bed_pkg::NUM_BUTTONS)
        begin : g_on
            assign merged.pressed_mask[j]        = lane_stat[j].held_next;
            assign merged.press_events_mask[j]   = lane_stat[j].press_hit;
            assign merged.release_events_mask[j] = lane_stat[j].release_hit;
            assign merged.long_events_mask[j]    = lane_stat[j].long_hit;
        end
        else
        begin : g_off
            assign merged.pressed_mask[j]        = 1'b0;
            assign merged.press_events_mask[j]   = 1'b0;
            assign merged.release_events_mask[j] = 1'b0;
            assign merged.long_events_mask[j]    = 1'b0;
        end
    end

    // at most one lane is selected by a read, so OR the gated read data
    always_comb
    begin
        rd_code    = bed_pkg::EV_NONE;
        rd_pressed = 1'b0;
        for (int i = 0; i < bed_pkg::NUM_BUTTONS; i++)
        begin
            rd_code    = rd_code | lane_stat[i].rd_event;
            rd_pressed = rd_pressed | lane_stat[i].rd_pressed;
        end
    end

    assign merged.event_code     = rd_code;
    assign merged.button_pressed = rd_pressed;

    assign pop = out_valid_reg & ~out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (take)
            begin
                out_data_next = merged;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (take)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = merged;
                out_valid_next = 1'b1;
            end
            else
            begin
                // hold the new transaction behind the stalled one
                skid_data_next  = merged;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign result    = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/button_event_detector.sv
// Top level of the button event detector: configuration, lanes and merge.
//
// Takes one transaction per clock unless in_stall is high and returns
// exactly one registered result per transaction. Every button has its
// own lane holding its level, press start time, long-press mark and pending
// event; a scan updates all lanes in the same cycle, each lane doing one
// 32-bit subtract and compare for the hold time. A two-entry output buffer
// keeps the input open while one result waits; in_stall rises only when
// both entries are occupied. Configuration writes take effect at the next
// clock edge and must be made while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module button_event_detector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      command,
    input  wire logic [bed_pkg::MASK_W-1:0]      pressed_levels,
    input  wire logic [bed_pkg::TIME_W-1:0]      now_ms,
    input  wire logic [bed_pkg::IDX_W-1:0]       button_index,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           event_code,
    output logic                                 button_pressed,
    output logic [bed_pkg::MASK_W-1:0]           pressed_mask,
    output logic [bed_pkg::MASK_W-1:0]           press_events_mask,
    output logic [bed_pkg::MASK_W-1:0]           release_events_mask,
    output logic [bed_pkg::MASK_W-1:0]           long_events_mask,
    input  wire logic                            cfg_we,
    input  wire logic [bed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bed_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [bed_pkg::TIME_W-1:0] long_press_ms_reg;
    logic [bed_pkg::TIME_W-1:0] long_press_ms_next;
    logic [bed_pkg::MASK_W-1:0] long_press_enable_reg;
    logic [bed_pkg::MASK_W-1:0] long_press_enable_next;

    logic                                           accept;
    logic                                           full;
    bed_pkg::lane_stat_t [bed_pkg::NUM_BUTTONS-1:0] lane_stat;
    bed_pkg::result_t                               result;

    always_comb
    begin
        long_press_ms_next     = long_press_ms_reg;
        long_press_enable_next = long_press_enable_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bed_pkg::REG_LONG_PRESS_MS:
                    long_press_ms_next = cfg_data;
                bed_pkg::REG_LONG_PRESS_ENABLE:
                    long_press_enable_next = cfg_data[bed_pkg::MASK_W-1:0];
                default:
                    long_press_ms_next = long_press_ms_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ms_reg     <= bed_pkg::LONG_PRESS_MS_RST;
            long_press_enable_reg <= bed_pkg::LONG_PRESS_ENABLE_RST;
        end
        else
        begin
            long_press_ms_reg     <= long_press_ms_next;
            long_press_enable_reg <= long_press_enable_next;
        end
    end

    assign in_stall = full;
    assign accept   = in_valid & ~full;

    for (genvar i = 0; i < bed_pkg::NUM_BUTTONS; i++)
    begin : g_lane
        bed_pkg::lane_ctrl_t ctrl;
        logic                level;
        logic                long_en;

        assign ctrl.accept    = accept;
        assign ctrl.scan      = (command == bed_pkg::CMD_SCAN);
        assign ctrl.read_hit  = (command == bed_pkg::CMD_READ) &&
                                ({28'd0, button_index} == 32'(i));
        assign ctrl.clear_all = (command == bed_pkg::CMD_CLEAR);

        // buttons beyond the level word are never pressed
        if (i < bed_pkg::MASK_W)
        begin : g_in
            assign level   = pressed_levels[i];
            assign long_en = long_press_enable_reg[i];
        end
        else
        begin : g_out
            assign level   = 1'b0;
            assign long_en = 1'b0;
        end

        bed_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .level         (level),
            .long_en       (long_en),
            .now_ms        (now_ms),
            .long_press_ms (long_press_ms_reg),
            .stat          (lane_stat[i])
        );
    end

    bed_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_stat (lane_stat),
        .take      (accept),
        .out_stall (out_stall),
        .full      (full),
        .out_valid (out_valid),
        .result    (result)
    );

    assign event_code          = result.event_code;
    assign button_pressed      = result.button_pressed;
    assign pressed_mask        = result.pressed_mask;
    assign press_events_mask   = result.press_events_mask;
    assign release_events_mask = result.release_events_mask;
    assign long_events_mask    = result.long_events_mask;

endmodule

`default_nettype wire
